/* hdl/gwww_pkg.sv */
package gwww_pkg;

  // Character codes with a role in the text stream
  localparam logic [7:0] CH_NUL = 8'd0;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_SP  = 8'd32;

  // Pixel width of a space between words
  localparam logic [17:0] SPACE_W = 18'd4;

  // Saturation limits
  localparam logic [15:0] W16_MAX = 16'hFFFF;
  localparam logic [16:0] W17_MAX = 17'h1FFFF;

  // Register map (word index taken from paddr[2])
  localparam logic REG_WRAP = 1'b0;
  localparam logic REG_CAP  = 1'b1;

  // Register reset values
  localparam logic [15:0] WRAP_RST = 16'hFFFF;
  localparam logic [15:0] CAP_RST  = 16'd1024;

  // Glyph widths for codes 0..127; control codes are zero width
  localparam logic [3:0] GLYPH_W [128] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
    4'd4, 4'd2, 4'd4, 4'd7, 4'd6, 4'd9, 4'd7, 4'd2,
    4'd3, 4'd3, 4'd4, 4'd6, 4'd3, 4'd5, 4'd2, 4'd7,
    4'd6, 4'd3, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
    4'd6, 4'd6, 4'd2, 4'd3, 4'd5, 4'd6, 4'd5, 4'd7,
    4'd8, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
    4'd6, 4'd4, 4'd6, 4'd6, 4'd5, 4'd8, 4'd8, 4'd6,
    4'd6, 4'd7, 4'd6, 4'd6, 4'd6, 4'd6, 4'd8, 4'd10,
    4'd8, 4'd6, 4'd6, 4'd3, 4'd6, 4'd3, 4'd6, 4'd6,
    4'd4, 4'd7, 4'd6, 4'd6, 4'd6, 4'd6, 4'd5, 4'd6,
    4'd6, 4'd2, 4'd5, 4'd5, 4'd2, 4'd9, 4'd6, 4'd6,
    4'd6, 4'd6, 4'd6, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6,
    4'd6, 4'd6, 4'd6, 4'd4, 4'd2, 4'd5, 4'd7, 4'd0
  };

  // Width of one byte; upper half of the code space has no glyph
  function automatic logic [3:0] glyph_width(input logic [7:0] c);
    return c[7] ? 4'd0 : GLYPH_W[c[6:0]];
  endfunction

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_WORD_RD,
    ST_WORD_EM,
    ST_CLOSE,
    ST_DONE,
    ST_END
  } state_t;

  // One result transaction
  typedef struct packed {
    logic [7:0]  out_char;
    logic        char_valid;
    logic        run_last;
    logic        text_done;
    logic [15:0] line_count;
    logic        truncated;
  } res_t;

endpackage

/* hdl/gwww_ifs.sv */
interface gwww_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_of_text;

  modport source (output valid, output in_char, output end_of_text, input ready);
  modport sink   (input valid, input in_char, input end_of_text, output ready);
endinterface

interface gwww_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_char;
  logic        char_valid;
  logic        run_last;
  logic        text_done;
  logic [15:0] line_count;
  logic        truncated;

  modport source (output valid, output out_char, output char_valid, output run_last,
                  output text_done, output line_count, output truncated, input ready);
  modport sink   (input valid, input out_char, input char_valid, input run_last,
                  input text_done, input line_count, input truncated, output ready);
endinterface

/* hdl/glyph_width_word_wrap.sv */
// Greedy word wrap over a byte stream using per-glyph pixel widths. Bytes come in on in_if;
// CR/LF end a line (runs collapse), spaces split words (runs collapse). Word bytes are kept
// in a TOKEN_DEPTH-entry word RAM; extra bytes are dropped but still add width, and the
// truncated flag rises. At a space, line break or end of text the buffered word is drained
// from the RAM onto out_if, preceded by a space or a newline depending on wrap_width
// (APB offset 0x0). At most out_capacity-1 characters (offset 0x4) go out per text; the
// rest are dropped. The last byte of a text is followed by a closing transaction with
// text_done and the line count, and the text state returns to reset.
// Sequencing: a plain word byte is stored and yields nothing. A space or line break runs
// through FLUSH, then WORD_RD and WORD_EM in turn for each buffered word byte, then CLOSE;
// end of text adds DONE, and END follows. The word RAM has a single read port, so reads
// and emits alternate, and results pass through the one-entry result holding stage in front
// of the output register; a busy output stalls the sequence. One item is in flight at a time.
module glyph_width_word_wrap #(
  parameter int TOKEN_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  gwww_in_if.sink     in_if,
  gwww_out_if.source  out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import gwww_pkg::*;

  localparam int AW = $clog2(TOKEN_DEPTH);
  localparam int LW = $clog2(TOKEN_DEPTH + 1);
  localparam logic [LW-1:0] DEPTH_L = LW'(TOKEN_DEPTH);

  // Registers
  state_t        state_r, state_nxt;
  logic [7:0]    char_r, char_nxt;
  logic          last_r, last_nxt;
  logic [LW-1:0] wl_r, wl_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  logic [15:0]   ww_r, ww_nxt;
  logic [16:0]   lw_r, lw_nxt;
  logic          lo_r, lo_nxt;
  logic [15:0]   lines_r, lines_nxt;
  logic [15:0]   chars_r, chars_nxt;
  logic          drop_r, drop_nxt;
  logic [15:0]   wrap_r, wrap_nxt;
  logic [15:0]   cap_r, cap_nxt;
  logic          pend_v_r, pend_v_nxt;
  res_t          pend_r, pend_nxt;
  logic          out_v_r, out_v_nxt;
  res_t          out_r, out_nxt;

  // Misc combinational
  logic          in_fire;
  logic          out_free;
  logic          can_emit;
  logic [15:0]   limit;
  logic          room;
  logic          is_brk;
  logic          is_spc;
  logic          in_brk;
  logic          in_spc;
  logic          closing;
  logic [15:0]   lines_inc;
  logic [16:0]   ww_sum;
  logic [17:0]   lw_ww;
  logic [17:0]   lw_sum;
  logic          ram_we;
  logic [7:0]    ram_rdata;

  // Generated result request
  logic          gen_v;
  logic          gen_force;
  res_t          gen_res;
  logic          emit;

  // Word store
  gwww_ram #(
    .WIDTH (8),
    .DEPTH (TOKEN_DEPTH)
  ) u_word_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wl_r[AW-1:0]),
    .wdata (in_if.in_char),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Handshake and helpers
  assign in_if.ready = (state_r == ST_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_free    = !out_v_r || out_if.ready;
  assign can_emit    = !pend_v_r || out_free;
  assign limit       = (cap_r == 16'd0) ? 16'd0 : cap_r - 16'd1;
  assign room        = chars_r < limit;
  assign is_brk      = (char_r == CH_CR) || (char_r == CH_LF);
  assign is_spc      = (char_r == CH_SP);
  assign in_brk      = (in_if.in_char == CH_CR) || (in_if.in_char == CH_LF);
  assign in_spc      = (in_if.in_char == CH_SP);
  assign closing     = is_brk || last_r;
  assign lines_inc   = (lines_r == W16_MAX) ? lines_r : lines_r + 16'd1;
  assign ww_sum      = {1'b0, ww_r} + {13'd0, glyph_width(in_if.in_char)};
  assign lw_ww       = {1'b0, lw_r} + {2'b0, ww_r};
  assign lw_sum      = lw_ww + SPACE_W;
  assign ram_we      = in_fire && !in_brk && !in_spc && (wl_r < DEPTH_L);

  // Output port
  assign out_if.valid      = out_v_r;
  assign out_if.out_char   = out_r.out_char;
  assign out_if.char_valid = out_r.char_valid;
  assign out_if.run_last   = out_r.run_last;
  assign out_if.text_done  = out_r.text_done;
  assign out_if.line_count = out_r.line_count;
  assign out_if.truncated  = out_r.truncated;

  // Configuration port
  assign pready = 1'b1;

  always_comb begin
    wrap_nxt = wrap_r;
    cap_nxt  = cap_r;
    if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_WRAP: wrap_nxt = pwdata[15:0];
        REG_CAP:  cap_nxt  = pwdata[15:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WRAP: prdata = {16'd0, wrap_r};
      REG_CAP:  prdata = {16'd0, cap_r};
      default:  prdata = 32'd0;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_brk || in_spc || in_if.end_of_text)) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (wl_r == '0) begin
          state_nxt = ST_CLOSE;
        end else if (can_emit) begin
          state_nxt = ST_WORD_RD;
        end
      end
      ST_WORD_RD: begin
        state_nxt = (idx_r == wl_r) ? ST_CLOSE : ST_WORD_EM;
      end
      ST_WORD_EM: begin
        if (can_emit) begin
          state_nxt = ST_WORD_RD;
        end
      end
      ST_CLOSE: begin
        if (can_emit) begin
          state_nxt = last_r ? ST_DONE : ST_END;
        end
      end
      ST_DONE: begin
        if (can_emit) begin
          state_nxt = ST_END;
        end
      end
      ST_END: begin
        if (!pend_v_r || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    char_nxt   = char_r;
    last_nxt   = last_r;
    wl_nxt     = wl_r;
    idx_nxt    = idx_r;
    ww_nxt     = ww_r;
    lw_nxt     = lw_r;
    lo_nxt     = lo_r;
    lines_nxt  = lines_r;
    chars_nxt  = chars_r;
    drop_nxt   = drop_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    out_v_nxt  = out_v_r && !out_if.ready;
    out_nxt    = out_r;
    gen_v      = 1'b0;
    gen_force  = 1'b0;
    gen_res    = '{out_char: CH_NUL, char_valid: 1'b1, run_last: 1'b0,
                   text_done: 1'b0, line_count: lines_r, truncated: drop_r};

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          char_nxt = in_if.in_char;
          last_nxt = in_if.end_of_text;
          if (!in_brk && !in_spc) begin
            // Word byte: store if room, width always counts
            if (wl_r < DEPTH_L) begin
              wl_nxt = wl_r + LW'(1);
            end else begin
              drop_nxt = 1'b1;
            end
            ww_nxt = ww_sum[16] ? W16_MAX : ww_sum[15:0];
            lo_nxt = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        // Separator ahead of a word that is not first on the line
        if (wl_r != '0 && can_emit) begin
          idx_nxt = '0;
          if (lw_r != '0) begin
            gen_v = 1'b1;
            if (lw_ww > {2'b0, wrap_r}) begin
              lw_nxt             = '0;
              lines_nxt          = lines_inc;
              gen_res.out_char   = CH_LF;
              gen_res.line_count = lines_inc;
            end else begin
              gen_res.out_char = CH_SP;
            end
          end
        end
      end
      ST_WORD_RD: begin
        // Word drained: advance the line width
        if (idx_r == wl_r) begin
          lw_nxt = lw_sum[17] ? W17_MAX : lw_sum[16:0];
          wl_nxt = '0;
          ww_nxt = '0;
        end
      end
      ST_WORD_EM: begin
        if (can_emit) begin
          gen_v            = 1'b1;
          gen_res.out_char = ram_rdata;
          idx_nxt          = idx_r + LW'(1);
        end
      end
      ST_CLOSE: begin
        if (can_emit) begin
          if (closing) begin
            if (lo_r || is_spc) begin
              gen_v              = 1'b1;
              lines_nxt          = lines_inc;
              gen_res.out_char   = CH_LF;
              gen_res.line_count = lines_inc;
            end
            lo_nxt = 1'b0;
            lw_nxt = '0;
          end else begin
            lo_nxt = lo_r || is_spc;
          end
        end
      end
      ST_DONE: begin
        if (can_emit) begin
          gen_v              = 1'b1;
          gen_force          = 1'b1;
          gen_res.char_valid = 1'b0;
          gen_res.text_done  = 1'b1;
          wl_nxt             = '0;
          ww_nxt             = '0;
          lw_nxt             = '0;
          lo_nxt             = 1'b0;
          lines_nxt          = '0;
          chars_nxt          = '0;
          drop_nxt           = 1'b0;
        end
      end
      ST_END: begin
        // Last result of the item goes out marked
        if (pend_v_r && out_free) begin
          out_nxt          = pend_r;
          out_nxt.run_last = 1'b1;
          out_v_nxt        = 1'b1;
          pend_v_nxt       = 1'b0;
        end
      end
      default: ;
    endcase

    // Capacity check; a produced result waits in the holding stage
    emit = gen_v && (gen_force || room);
    if (gen_v && !gen_force && !room) begin
      drop_nxt = 1'b1;
    end
    if (emit) begin
      if (!gen_force) begin
        chars_nxt = chars_r + 16'd1;
      end
      if (pend_v_r) begin
        out_nxt   = pend_r;
        out_v_nxt = 1'b1;
      end
      pend_nxt   = gen_res;
      pend_v_nxt = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      wl_r     <= '0;
      ww_r     <= '0;
      lw_r     <= '0;
      lo_r     <= 1'b0;
      lines_r  <= '0;
      chars_r  <= '0;
      drop_r   <= 1'b0;
      wrap_r   <= WRAP_RST;
      cap_r    <= CAP_RST;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wl_r     <= wl_nxt;
      ww_r     <= ww_nxt;
      lw_r     <= lw_nxt;
      lo_r     <= lo_nxt;
      lines_r  <= lines_nxt;
      chars_r  <= chars_nxt;
      drop_r   <= drop_nxt;
      wrap_r   <= wrap_nxt;
      cap_r    <= cap_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    last_r <= last_nxt;
    idx_r  <= idx_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

`ifndef SYNTH
  // No result left behind when a new byte is taken
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.ready |-> !pend_v_r)
    else $error("holding stage not empty while accepting input");

  // Word count never passes the store depth
  a_wl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wl_r <= DEPTH_L)
    else $error("word length beyond store depth");

  // Drain only reads entries of the current word
  a_drain_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WORD_EM) |-> (idx_r < wl_r))
    else $error("word drain index out of range");

  // Closing transaction is always the last of its item
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.text_done) |-> out_r.run_last)
    else $error("closing transaction not marked last");

  // A closing transaction clears the text counters
  a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && can_emit) |=> (lines_r == '0 && chars_r == '0 && !drop_r))
    else $error("text state not cleared after closing");
`endif

endmodule

/* hdl/gwww_ram.sv */
module gwww_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
